// ===== design/affine_rotation_compose_unit_assert.svh =====
// ============================================================================
// Affine rotation composer assertion macros
// Implication and next-cycle implication checks, clocked and reset-qualified.
// ============================================================================
`ifndef AFFINE_ROTATION_COMPOSE_UNIT_ASSERT_SVH
`define AFFINE_ROTATION_COMPOSE_UNIT_ASSERT_SVH

// same-cycle implication
`define ARC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/arc_pkg.sv =====
// ============================================================================
// Affine rotation composer package
// Shared widths, codes, controller command struct and lookup functions.
// ============================================================================
package arc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_ENT   = 6;
    localparam int ENT_IDX_W = 3;
    localparam int STEP_W    = 5;
    localparam int TERM_W    = 4;
    localparam int MAC_TERMS = 12;

    // CORDIC works in Q2.30 with headroom
    localparam int CORD_W  = 34;
    localparam int Q_FRAC  = 30;
    localparam int TURN_SH = Q_FRAC - (ANGLE_W - 2);

    localparam logic [CORD_W-1:0] CORDIC_START_X = 34'h026DD3B6A;

    // entry order a, b, c, d, v, w; also the config register index
    localparam logic [ENT_IDX_W-1:0] ENT_A = 3'd0;
    localparam logic [ENT_IDX_W-1:0] ENT_B = 3'd1;
    localparam logic [ENT_IDX_W-1:0] ENT_C = 3'd2;
    localparam logic [ENT_IDX_W-1:0] ENT_D = 3'd3;
    localparam logic [ENT_IDX_W-1:0] ENT_V = 3'd4;
    localparam logic [ENT_IDX_W-1:0] ENT_W = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ROT_POS = 2'd0,
        MODE_ROT_NEG = 2'd1,
        MODE_RELOAD  = 2'd2,
        MODE_HOLD    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORD,
        ST_TRIG,
        ST_MAC,
        ST_COMMIT,
        ST_LOAD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CF_COS,
        CF_SIN,
        CF_NSIN
    } t_coef;

    typedef struct packed {
        logic              cord_init;
        logic              cord_step;
        logic              trig;
        logic              mac_mul;
        logic              mac_acc;
        logic [STEP_W-1:0] step;
        logic              commit;
        logic              reload;
        logic              load_out;
    } t_cmd;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [CORD_W-1:0] atan_unit(input logic [STEP_W-1:0] idx);
        logic [CORD_W-1:0] v;
        case (idx)
            5'd0:    v = 34'h020000000;
            5'd1:    v = 34'h012E4051E;
            5'd2:    v = 34'h009FB385B;
            5'd3:    v = 34'h0051111D4;
            5'd4:    v = 34'h0028B0D43;
            5'd5:    v = 34'h00145D7E1;
            5'd6:    v = 34'h000A2F61E;
            5'd7:    v = 34'h000517C55;
            5'd8:    v = 34'h00028BE53;
            5'd9:    v = 34'h000145F2F;
            5'd10:   v = 34'h0000A2F98;
            5'd11:   v = 34'h0000517CC;
            5'd12:   v = 34'h000028BE6;
            5'd13:   v = 34'h0000145F3;
            5'd14:   v = 34'h00000A2FA;
            5'd15:   v = 34'h00000517D;
            5'd16:   v = 34'h0000028BE;
            5'd17:   v = 34'h00000145F;
            5'd18:   v = 34'h000000A30;
            5'd19:   v = 34'h000000518;
            5'd20:   v = 34'h00000028C;
            5'd21:   v = 34'h000000146;
            5'd22:   v = 34'h0000000A3;
            5'd23:   v = 34'h000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // live entry feeding a product term: even term x operand, odd term y operand
    function automatic logic [ENT_IDX_W-1:0] opnd_idx(input logic [TERM_W-1:0] term);
        logic [ENT_IDX_W-1:0] e;
        logic [ENT_IDX_W-1:0] r;
        e = term[TERM_W-1:1];
        case (e) inside
            ENT_A, ENT_C: r = term[0] ? ENT_C : ENT_A;
            ENT_B, ENT_D: r = term[0] ? ENT_D : ENT_B;
            default:      r = term[0] ? ENT_W : ENT_V;
        endcase
        return r;
    endfunction

    // coefficient of a product term: top row cos, -sin; bottom row sin, cos
    function automatic t_coef coef_sel(input logic [TERM_W-1:0] term);
        logic [ENT_IDX_W-1:0] e;
        t_coef                r;
        e = term[TERM_W-1:1];
        case (e) inside
            ENT_A, ENT_B, ENT_V: r = term[0] ? CF_NSIN : CF_COS;
            default:             r = term[0] ? CF_COS : CF_SIN;
        endcase
        return r;
    endfunction

endpackage

// ===== design/arc_in_if.sv =====
// ============================================================================
// Affine rotation composer input channel
// Valid/ready channel carrying mode and angle of one item.
// ============================================================================
interface arc_in_if;
    logic                          valid;
    logic                          ready;
    logic [arc_pkg::MODE_W-1:0]    mode;
    logic [arc_pkg::ANGLE_W-1:0]   angle;

    modport src (output valid, output mode, output angle, input ready);
    modport snk (input valid, input mode, input angle, output ready);
endinterface

// ===== design/arc_out_if.sv =====
// ============================================================================
// Affine rotation composer output channel
// Valid/ready channel carrying the six transform entries of one item.
// ============================================================================
interface arc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [arc_pkg::DATA_W-1:0]  out_a;
    logic signed [arc_pkg::DATA_W-1:0]  out_b;
    logic signed [arc_pkg::DATA_W-1:0]  out_c;
    logic signed [arc_pkg::DATA_W-1:0]  out_d;
    logic signed [arc_pkg::DATA_W-1:0]  out_v;
    logic signed [arc_pkg::DATA_W-1:0]  out_w;

    modport src (output valid, output out_a, output out_b, output out_c,
                 output out_d, output out_v, output out_w, input ready);
    modport snk (input valid, input out_a, input out_b, input out_c,
                 input out_d, input out_v, input out_w, output ready);
endinterface

// ===== design/arc_ctrl.sv =====
// ============================================================================
// Affine rotation composer controller
// Sequences CORDIC, trig rounding, multiply-accumulate, reload and result hand-off.
// ============================================================================
module arc_ctrl #(
    parameter int CORDIC_STEPS = arc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [arc_pkg::MODE_W-1:0] i_mode,
    output logic                       o_in_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output arc_pkg::t_cmd              o_cmd
);

    localparam logic [arc_pkg::STEP_W-1:0] LAST_CORD = arc_pkg::STEP_W'(CORDIC_STEPS - 1);
    localparam logic [arc_pkg::STEP_W-1:0] LAST_MAC  = arc_pkg::STEP_W'(arc_pkg::MAC_TERMS);

    arc_pkg::t_state              r_state, n_state;
    logic [arc_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_out_valid, n_out_valid;
    arc_pkg::t_mode               s_mode;
    logic                         s_slot_free;

    assign s_mode      = arc_pkg::t_mode'(i_mode);
    assign s_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arc_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            arc_pkg::ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    unique case (s_mode)
                        arc_pkg::MODE_ROT_POS: n_state = arc_pkg::ST_CORD;
                        arc_pkg::MODE_ROT_NEG: n_state = arc_pkg::ST_CORD;
                        arc_pkg::MODE_RELOAD:  n_state = arc_pkg::ST_LOAD;
                        default:               n_state = arc_pkg::ST_DONE;
                    endcase
                end
            end
            arc_pkg::ST_CORD: begin
                if (r_step == LAST_CORD) begin
                    n_state = arc_pkg::ST_TRIG;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            arc_pkg::ST_TRIG: begin
                n_state = arc_pkg::ST_MAC;
                n_step  = '0;
            end
            arc_pkg::ST_MAC: begin
                if (r_step == LAST_MAC) begin
                    n_state = arc_pkg::ST_COMMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            arc_pkg::ST_COMMIT: n_state = arc_pkg::ST_DONE;
            arc_pkg::ST_LOAD:   n_state = arc_pkg::ST_DONE;
            arc_pkg::ST_DONE: begin
                if (s_slot_free) begin
                    n_state = arc_pkg::ST_IDLE;
                end
            end
            default: n_state = arc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_in_ready  = 1'b0;
        unique case (r_state)
            arc_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.cord_init = i_in_valid && (s_mode == arc_pkg::MODE_ROT_POS ||
                                                 s_mode == arc_pkg::MODE_ROT_NEG);
            end
            arc_pkg::ST_CORD:   o_cmd.cord_step = 1'b1;
            arc_pkg::ST_TRIG:   o_cmd.trig      = 1'b1;
            arc_pkg::ST_MAC: begin
                o_cmd.mac_mul = (r_step != LAST_MAC);
                o_cmd.mac_acc = (r_step != '0);
            end
            arc_pkg::ST_COMMIT: o_cmd.commit    = 1'b1;
            arc_pkg::ST_LOAD:   o_cmd.reload    = 1'b1;
            arc_pkg::ST_DONE:   o_cmd.load_out  = s_slot_free;
            default: ;
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/arc_dpath.sv =====
// ============================================================================
// Affine rotation composer datapath
// CORDIC unit, shared multiply-accumulate, transform and start registers.
// ============================================================================
module arc_dpath #(
    parameter int FRAC_BITS = arc_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  arc_pkg::t_cmd                     i_cmd,
    input  logic [arc_pkg::MODE_W-1:0]        i_mode,
    input  logic [arc_pkg::ANGLE_W-1:0]       i_angle,
    input  logic                              i_cfg_we,
    input  logic [arc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [arc_pkg::DATA_W-1:0]        i_cfg_data,
    output logic signed [arc_pkg::DATA_W-1:0] o_res [arc_pkg::NUM_ENT]
);

    localparam int DW     = arc_pkg::DATA_W;
    localparam int CW     = arc_pkg::CORD_W;
    localparam int CS_W   = FRAC_BITS + 3;
    localparam int PROD_W = CS_W + DW;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RSH    = arc_pkg::Q_FRAC - FRAC_BITS;

    localparam logic signed [DW-1:0]    ONE_Q   = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [DW-1:0]    SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]    SAT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [CW:0]      RND_T   = {{CW{1'b0}}, 1'b1} << (RSH - 1);
    localparam logic signed [SUM_W-1:0] RND_P   = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [DW-1:0]     r_start [arc_pkg::NUM_ENT];
    logic signed [DW-1:0]     r_live  [arc_pkg::NUM_ENT];
    logic signed [DW-1:0]     r_nxt   [arc_pkg::NUM_ENT];
    logic signed [DW-1:0]     r_res   [arc_pkg::NUM_ENT];
    logic signed [CW-1:0]     r_x, r_y, r_z;
    logic [1:0]               r_quad;
    logic                     r_neg;
    logic signed [CS_W-1:0]   r_cos, r_sin, r_nsin;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;

    // CORDIC step
    logic signed [CW-1:0] s_xsh, s_ysh, s_at;
    logic signed [CW-1:0] n_x, n_y, n_z;

    always_comb begin
        s_xsh = r_x >>> i_cmd.step;
        s_ysh = r_y >>> i_cmd.step;
        s_at  = $signed(arc_pkg::atan_unit(i_cmd.step));
        if (!r_z[CW-1]) begin
            n_x = r_x - s_ysh;
            n_y = r_y + s_xsh;
            n_z = r_z - s_at;
        end else begin
            n_x = r_x + s_ysh;
            n_y = r_y - s_xsh;
            n_z = r_z + s_at;
        end
    end

    // quadrant fold and rounding to FRAC_BITS
    logic signed [CW:0] s_xe, s_ye, s_c, s_s, s_cr, s_sr, s_sv, s_nsv;

    always_comb begin
        s_xe = (CW + 1)'(r_x);
        s_ye = (CW + 1)'(r_y);
        case (r_quad)
            QUAD_0: begin
                s_c = s_xe;
                s_s = s_ye;
            end
            QUAD_1: begin
                s_c = -s_ye;
                s_s = s_xe;
            end
            QUAD_2: begin
                s_c = -s_xe;
                s_s = -s_ye;
            end
            default: begin
                s_c = s_ye;
                s_s = -s_xe;
            end
        endcase
        s_cr  = (s_c + RND_T) >>> RSH;
        s_sr  = (s_s + RND_T) >>> RSH;
        s_sv  = r_neg ? -s_sr : s_sr;
        s_nsv = -s_sv;
    end

    // multiply-accumulate
    logic [arc_pkg::TERM_W-1:0]    s_mul_term, s_acc_term;
    logic signed [CS_W-1:0]        s_coef;
    logic signed [DW-1:0]          s_opnd;
    logic signed [PROD_W-1:0]      s_prod;
    logic signed [SUM_W-1:0]       s_prod_x, s_sum, s_shd;
    logic signed [DW-1:0]          s_sat;
    logic [arc_pkg::ENT_IDX_W-1:0] s_ent;

    always_comb begin
        s_mul_term = i_cmd.step[arc_pkg::TERM_W-1:0];
        s_acc_term = s_mul_term - arc_pkg::TERM_W'(1);
        s_ent      = s_acc_term[arc_pkg::TERM_W-1:1];
        case (arc_pkg::coef_sel(s_mul_term))
            arc_pkg::CF_SIN:  s_coef = r_sin;
            arc_pkg::CF_NSIN: s_coef = r_nsin;
            default:          s_coef = r_cos;
        endcase
        s_opnd   = r_live[arc_pkg::opnd_idx(s_mul_term)];
        s_prod   = s_coef * s_opnd;
        s_prod_x = SUM_W'(r_prod);
        s_sum    = r_acc + s_prod_x;
        s_shd    = s_sum >>> FRAC_BITS;
        if (s_shd[SUM_W-1] && !(&s_shd[SUM_W-1:DW-1])) begin
            s_sat = SAT_MIN;
        end else if (!s_shd[SUM_W-1] && (|s_shd[SUM_W-1:DW-1])) begin
            s_sat = SAT_MAX;
        end else begin
            s_sat = s_shd[DW-1:0];
        end
    end

    // start registers and live transform
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < arc_pkg::NUM_ENT; k++) begin
                if (k == int'(arc_pkg::ENT_A) || k == int'(arc_pkg::ENT_D)) begin
                    r_start[k] <= ONE_Q;
                    r_live[k]  <= ONE_Q;
                end else begin
                    r_start[k] <= '0;
                    r_live[k]  <= '0;
                end
            end
        end else begin
            if (i_cfg_we && (i_cfg_idx < arc_pkg::CFG_IDX_W'(arc_pkg::NUM_ENT))) begin
                r_start[i_cfg_idx] <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_live <= r_nxt;
            end else if (i_cmd.reload) begin
                r_live <= r_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cord_init) begin
            r_x    <= arc_pkg::CORDIC_START_X;
            r_y    <= '0;
            r_z    <= {{(CW - arc_pkg::Q_FRAC){1'b0}}, i_angle[arc_pkg::ANGLE_W-3:0],
                       {arc_pkg::TURN_SH{1'b0}}};
            r_quad <= i_angle[arc_pkg::ANGLE_W-1:arc_pkg::ANGLE_W-2];
            r_neg  <= (arc_pkg::t_mode'(i_mode) == arc_pkg::MODE_ROT_NEG);
        end else if (i_cmd.cord_step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        if (i_cmd.trig) begin
            r_cos  <= s_cr[CS_W-1:0];
            r_sin  <= s_sv[CS_W-1:0];
            r_nsin <= s_nsv[CS_W-1:0];
        end
        if (i_cmd.mac_mul) begin
            r_prod <= s_prod;
        end
        if (i_cmd.mac_acc) begin
            if (!s_acc_term[0]) begin
                r_acc <= s_prod_x + RND_P;
            end else begin
                r_nxt[s_ent] <= s_sat;
            end
        end
        if (i_cmd.load_out) begin
            r_res <= r_live;
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/affine_rotation_compose_unit.sv =====
// ============================================================================
// Affine rotation composer: left-multiplies a Q16.16 affine transform by a rotation
// Rotate: one CORDIC step per cycle, then twelve products through one multiplier.
// Reload: the transform is restored from the start registers; hold: left unchanged.
// A new item is taken only once the previous result is in the output register.
// Reset (sync, active low): start registers and transform to identity, zero offset.
// ============================================================================
`include "affine_rotation_compose_unit_assert.svh"

module affine_rotation_compose_unit #(
    parameter int FRAC_BITS    = arc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = arc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    arc_in_if.snk                         i_in,
    arc_out_if.src                        o_out,
    input  logic                          i_cfg_we,
    input  logic [arc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [arc_pkg::DATA_W-1:0]    i_cfg_data
);

    arc_pkg::t_cmd                     s_cmd;
    logic                              s_in_ready;
    logic                              s_out_valid;
    logic                              s_in_acc;
    logic signed [arc_pkg::DATA_W-1:0] s_res [arc_pkg::NUM_ENT];

    arc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (s_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (s_out_valid),
        .o_cmd       (s_cmd)
    );

    arc_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .i_mode     (i_in.mode),
        .i_angle    (i_in.angle),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (s_res)
    );

    assign i_in.ready  = s_in_ready;
    assign o_out.valid = s_out_valid;
    assign o_out.out_a = s_res[arc_pkg::ENT_A];
    assign o_out.out_b = s_res[arc_pkg::ENT_B];
    assign o_out.out_c = s_res[arc_pkg::ENT_C];
    assign o_out.out_d = s_res[arc_pkg::ENT_D];
    assign o_out.out_v = s_res[arc_pkg::ENT_V];
    assign o_out.out_w = s_res[arc_pkg::ENT_W];

    assign s_in_acc = i_in.valid && s_in_ready;

    `ARC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_in_acc, !s_in_ready, "item taken while busy")
    `ARC_ASSERT_IMP(a_load_into_free, i_clk, i_rst_n, s_cmd.load_out, !s_out_valid || o_out.ready, "result overwritten")
    `ARC_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, s_cmd.load_out, s_out_valid, "result not presented")

endmodule
